FILE: src/ecl_pkg.sv
// Shared types and codes for the extent cache LRU tag manager.
// No dependencies; every module of the block imports this package.
package ecl_pkg;

    // operation codes of an input word
    localparam logic [1:0] OP_ACQUIRE = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [1:0] OP_FILLED  = 2'd3;

    // result status codes
    localparam logic [2:0] ST_HIT       = 3'd0;
    localparam logic [2:0] ST_MISS      = 3'd1;
    localparam logic [2:0] ST_NO_FREE   = 3'd2;
    localparam logic [2:0] ST_REF_FULL  = 3'd3;
    localparam logic [2:0] ST_RELEASED  = 3'd4;
    localparam logic [2:0] ST_REL_ERROR = 3'd5;
    localparam logic [2:0] ST_FILLED    = 3'd6;
    localparam logic [2:0] ST_CLEARED   = 3'd7;

    // slot update kinds sent to the cells
    localparam logic [2:0] UPD_NONE  = 3'd0;
    localparam logic [2:0] UPD_HIT   = 3'd1;
    localparam logic [2:0] UPD_FILL  = 3'd2;
    localparam logic [2:0] UPD_REL   = 3'd3;
    localparam logic [2:0] UPD_CLEAR = 3'd4;
    localparam logic [2:0] UPD_DONE  = 3'd5;

    localparam logic [7:0] REF_MAX    = 8'hFF;
    localparam logic       ERROR_FLAG = 1'b1;

    // request held for the whole sweep
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  dev;
        logic [31:0] start;
        logic [31:0] ebytes;
        logic [31:0] off;
        logic [16:0] len;     // already clamped
        logic [2:0]  si;
        logic        no_cache;
        logic        fill_failed;
    } t_req;

    // search token handed from cell to cell
    typedef struct packed {
        logic        hit;
        logic        full;
        logic [31:0] base;
        logic [16:0] size;
        logic        err;
        logic        vic;
        logic [31:0] vtime;
        logic [7:0]  sel_ref;
    } t_tok;

    // slot update broadcast
    typedef struct packed {
        logic [2:0]  kind;
        logic        stamp;
        logic [31:0] stamp_val;
        logic [31:0] base;
        logic [16:0] size;
        logic        err;
    } t_upd;

endpackage

FILE: src/extent_cache_lru_manager_core.sv
// Extent cache LRU tag manager, top level.
// The search token walks the chain of slot cells, each cell registering it for
// the next, and the result then passes the output register; the response waits
// while an earlier result word is still held.
// A new word is taken only once the previous result word has been registered.
// Reset (synchronous, active low) empties every slot and zeroes the use counter.
module extent_cache_lru_manager_core #(
    parameter int SLOTS       = 8,
    parameter int LINE_BYTES  = 65536,
    parameter int BLOCK_BYTES = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_device_id,
    input  logic [31:0] i_extent_start,
    input  logic [31:0] i_extent_bytes,
    input  logic [31:0] i_byte_offset,
    input  logic [16:0] i_request_bytes,
    input  logic [2:0]  i_slot_index,
    input  logic        i_no_cache,
    input  logic        i_fill_failed,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [2:0]  o_slot,
    output logic [31:0] o_window_offset,
    output logic [16:0] o_window_bytes,
    output logic [31:0] o_fill_block,
    output logic [5:0]  o_fill_blocks,
    output logic        o_slot_error
);
    import ecl_pkg::*;

    localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BLG = $clog2(BLOCK_BYTES);
    localparam logic [16:0] LINE17 = 17'(LINE_BYTES);
    localparam logic [17:0] BLK_M1 = 18'(BLOCK_BYTES - 1);
    localparam logic [IW-1:0] LAST_CNT = IW'(SLOTS - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_RESP  = 2'd2;

    logic [1:0]    r_state;
    logic [IW-1:0] r_cnt;
    t_req          r_req;
    logic [31:0]   r_use_cnt;
    logic [16:0]   len_clamp;

    t_tok          tok   [SLOTS+1];
    logic [IW-1:0] hidx  [SLOTS+1];
    logic [IW-1:0] vidx  [SLOTS+1];
    t_upd          upd;
    logic [IW-1:0] upd_idx;

    // refill window arithmetic
    logic [31:0] blockoff, fill_base, remain;
    logic [16:0] rem17, fill_size;
    logic [7:0]  blocks;
    logic [17:0] blk_sum;

    // response word
    logic [2:0]  n_status, n_slot;
    logic [31:0] n_woff, n_fblk;
    logic [16:0] n_wbytes;
    logic [5:0]  n_fcnt;
    logic        n_err, si_ok, can_resp;

    assign o_ready  = (r_state == S_IDLE);
    assign can_resp = !o_valid || i_ready;

    // clamp the requested length to the extent and the line
    always_comb begin
        len_clamp = i_request_bytes;
        if ({15'd0, len_clamp} > i_extent_bytes) len_clamp = i_extent_bytes[16:0];
        if (len_clamp > LINE17) len_clamp = LINE17;
    end

    // control sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_use_cnt <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_SWEEP;
                        r_cnt   <= '0;
                    end
                end
                S_SWEEP: begin
                    r_cnt <= r_cnt + IW'(1);
                    if (r_cnt == LAST_CNT) r_state <= S_RESP;
                end
                S_RESP: begin
                    if (can_resp) begin
                        r_state <= S_IDLE;
                        if (upd.stamp) r_use_cnt <= r_use_cnt + 32'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req.op          <= i_operation;
            r_req.dev         <= i_device_id;
            r_req.start       <= i_extent_start;
            r_req.ebytes      <= i_extent_bytes;
            r_req.off         <= i_byte_offset;
            r_req.len         <= len_clamp;
            r_req.si          <= i_slot_index;
            r_req.no_cache    <= i_no_cache;
            r_req.fill_failed <= i_fill_failed;
        end
    end

    // chain of slot cells
    assign tok[0]  = '0;
    assign hidx[0] = '0;
    assign vidx[0] = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        ecl_cell #(.SLOTS(SLOTS), .IDX(g), .IW(IW)) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_req     (r_req),
            .i_tok     (tok[g]),
            .i_hit_idx (hidx[g]),
            .i_vic_idx (vidx[g]),
            .i_upd     (upd),
            .i_upd_idx (upd_idx),
            .o_tok     (tok[g+1]),
            .o_hit_idx (hidx[g+1]),
            .o_vic_idx (vidx[g+1])
        );
    end

    // block-aligned window for a refill
    always_comb begin
        blockoff  = r_req.off >> BLG;
        fill_base = blockoff << BLG;
        remain    = (r_req.off < r_req.ebytes) ? (r_req.ebytes - r_req.off) : 32'd0;
        rem17     = (remain > {15'd0, LINE17}) ? LINE17 : remain[16:0];
        blk_sum   = {1'b0, rem17} + BLK_M1;
        blocks    = 8'(blk_sum >> BLG);
        if (blocks == 8'd0) blocks = 8'd1;
        fill_size = 17'({17'd0, blocks} << BLG);
    end

    // decide result and slot update
    always_comb begin
        n_status = ST_NO_FREE;
        n_slot   = 3'd0;
        n_woff   = '0;
        n_wbytes = '0;
        n_fblk   = '0;
        n_fcnt   = '0;
        n_err    = 1'b0;
        upd      = '0;
        upd_idx  = '0;
        si_ok    = (32'(r_req.si) < SLOTS);
        case (r_req.op)
            OP_ACQUIRE: begin
                if (tok[SLOTS].hit) begin
                    n_slot = 3'(hidx[SLOTS]);
                    if (tok[SLOTS].full) begin
                        n_status = ST_REF_FULL;
                    end else begin
                        n_status = ST_HIT;
                        n_woff   = tok[SLOTS].base;
                        n_wbytes = tok[SLOTS].size;
                        n_err    = tok[SLOTS].err;
                        upd.kind = UPD_HIT;
                        upd_idx  = hidx[SLOTS];
                    end
                end else if (tok[SLOTS].vic) begin
                    n_status = ST_MISS;
                    n_slot   = 3'(vidx[SLOTS]);
                    n_woff   = fill_base;
                    n_wbytes = fill_size;
                    n_fblk   = r_req.start + blockoff;
                    n_fcnt   = blocks[5:0];
                    upd.kind = UPD_FILL;
                    upd.base = fill_base;
                    upd.size = fill_size;
                    upd_idx  = vidx[SLOTS];
                end
            end
            OP_RELEASE: begin
                n_slot = r_req.si;
                if (!si_ok || tok[SLOTS].sel_ref == 8'd0) begin
                    n_status = ST_REL_ERROR;
                end else begin
                    n_status      = ST_RELEASED;
                    upd.kind      = UPD_REL;
                    upd.stamp     = (tok[SLOTS].sel_ref == 8'd1) && !r_req.no_cache;
                    upd.stamp_val = r_use_cnt;
                    upd_idx       = IW'(r_req.si);
                end
            end
            OP_CLEAR: begin
                n_status = ST_CLEARED;
                upd.kind = UPD_CLEAR;
            end
            default: begin
                n_status = ST_FILLED;
                n_slot   = r_req.si;
                if (si_ok) begin
                    n_err    = r_req.fill_failed ? ERROR_FLAG : 1'b0;
                    upd.kind = UPD_DONE;
                    upd.err  = n_err;
                    upd_idx  = IW'(r_req.si);
                end
            end
        endcase
        // updates land only when the response word is loaded into the output register
        if (!(r_state == S_RESP && can_resp)) upd = '0;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (r_state == S_RESP && can_resp) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RESP && can_resp) begin
            o_status        <= n_status;
            o_slot          <= n_slot;
            o_window_offset <= n_woff;
            o_window_bytes  <= n_wbytes;
            o_fill_block    <= n_fblk;
            o_fill_blocks   <= n_fcnt;
            o_slot_error    <= n_err;
        end
    end

endmodule

FILE: src/ecl_cell.sv
// One cache slot: holds its tag, window and policy state, merges its
// own match into the search token and registers it for the next cell.
// Depends on ecl_pkg.
module ecl_cell #(
    parameter int SLOTS = 8,
    parameter int IDX   = 0,
    parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ecl_pkg::t_req  i_req,
    input  ecl_pkg::t_tok  i_tok,
    input  logic [IW-1:0]  i_hit_idx,
    input  logic [IW-1:0]  i_vic_idx,
    input  ecl_pkg::t_upd  i_upd,
    input  logic [IW-1:0]  i_upd_idx,
    output ecl_pkg::t_tok  o_tok,
    output logic [IW-1:0]  o_hit_idx,
    output logic [IW-1:0]  o_vic_idx
);
    import ecl_pkg::*;

    localparam logic [IW-1:0] ME  = IW'(IDX);
    localparam logic [7:0]    ME8 = 8'(IDX);

    logic [7:0]  r_dev;
    logic [31:0] r_start, r_len, r_base, r_use;
    logic [16:0] r_size;
    logic [7:0]  r_ref;
    logic        r_err;

    t_tok          r_tok, n_tok;
    logic [IW-1:0] r_hit_idx, n_hit_idx, r_vic_idx, n_vic_idx;
    logic          mine_hit, mine;

    // local match against the request
    always_comb begin
        mine_hit = (r_size != 17'd0) && (r_dev == i_req.dev) &&
                   (r_start == i_req.start) && (r_len == i_req.ebytes) &&
                   (r_base <= i_req.off) &&
                   ({1'b0, r_base} + 33'(r_size) >= {1'b0, i_req.off} + 33'(i_req.len));
    end

    // token merge: earliest hit wins, oldest unreferenced slot wins
    always_comb begin
        n_tok     = i_tok;
        n_hit_idx = i_hit_idx;
        n_vic_idx = i_vic_idx;
        if (!i_tok.hit && mine_hit) begin
            n_tok.hit  = 1'b1;
            n_tok.full = (r_ref == REF_MAX);
            n_tok.base = r_base;
            n_tok.size = r_size;
            n_tok.err  = r_err;
            n_hit_idx  = ME;
        end
        if (r_ref == 8'd0 && (!i_tok.vic || r_use < i_tok.vtime)) begin
            n_tok.vic   = 1'b1;
            n_tok.vtime = r_use;
            n_vic_idx   = ME;
        end
        if ({5'd0, i_req.si} == ME8) begin
            n_tok.sel_ref = r_ref;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok     <= n_tok;
        r_hit_idx <= n_hit_idx;
        r_vic_idx <= n_vic_idx;
    end

    assign mine = (i_upd_idx == ME);

    // slot state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev   <= '0;
            r_start <= '0;
            r_len   <= '0;
            r_base  <= '0;
            r_size  <= '0;
            r_ref   <= '0;
            r_use   <= '0;
            r_err   <= 1'b0;
        end else begin
            case (i_upd.kind)
                UPD_HIT: begin
                    if (mine) r_ref <= r_ref + 8'd1;
                end
                UPD_FILL: begin
                    if (mine) begin
                        r_dev   <= i_req.dev;
                        r_start <= i_req.start;
                        r_len   <= i_req.ebytes;
                        r_base  <= i_upd.base;
                        r_size  <= i_upd.size;
                        r_err   <= 1'b0;
                        r_ref   <= 8'd1;
                    end
                end
                UPD_REL: begin
                    if (mine) begin
                        r_ref <= r_ref - 8'd1;
                        if (i_upd.stamp) r_use <= i_upd.stamp_val;
                    end
                end
                UPD_CLEAR: begin
                    if (r_dev == i_req.dev) begin
                        r_size <= '0;
                        r_use  <= '0;
                        r_ref  <= '0;
                    end
                end
                UPD_DONE: begin
                    if (mine) r_err <= i_upd.err;
                end
                default: ;
            endcase
        end
    end

    assign o_tok     = r_tok;
    assign o_hit_idx = r_hit_idx;
    assign o_vic_idx = r_vic_idx;

endmodule
